/* sv/smeu_pkg.sv */
`timescale 1ns / 1ps

package smeu_pkg;

  localparam int WORD_W      = 32;
  localparam int TALLY_W     = 6;
  localparam int MAX_RESULTS = 33;   // print all stops after this many numbers
  localparam int MAX_TEXT    = 32;   // string commands take at most this many chars

  localparam logic [WORD_W-1:0] LINE_FEED = WORD_W'(10);

  // command codes
  localparam logic [3:0] CMD_PUSH    = 4'd0;
  localparam logic [3:0] CMD_ADD     = 4'd1;
  localparam logic [3:0] CMD_SUB     = 4'd2;
  localparam logic [3:0] CMD_MUL     = 4'd3;
  localparam logic [3:0] CMD_DIV     = 4'd4;
  localparam logic [3:0] CMD_MOD     = 4'd5;
  localparam logic [3:0] CMD_PRINT   = 4'd6;
  localparam logic [3:0] CMD_TOP     = 4'd7;
  localparam logic [3:0] CMD_CHAR    = 4'd8;
  localparam logic [3:0] CMD_STRING  = 4'd9;
  localparam logic [3:0] CMD_RSTRING = 4'd10;

  // result kinds
  localparam logic [1:0] KIND_NUMBER = 2'd0;
  localparam logic [1:0] KIND_CHAR   = 2'd1;
  localparam logic [1:0] KIND_LINE   = 2'd2;
  localparam logic [1:0] KIND_ERROR  = 2'd3;

  // error codes
  localparam logic [2:0] ERR_NONE       = 3'd0;
  localparam logic [2:0] ERR_TOO_FEW    = 3'd1;
  localparam logic [2:0] ERR_DIV_ZERO   = 3'd2;
  localparam logic [2:0] ERR_EMPTY_TOP  = 3'd3;
  localparam logic [2:0] ERR_EMPTY_CHAR = 3'd4;
  localparam logic [2:0] ERR_CHAR_RANGE = 3'd5;
  localparam logic [2:0] ERR_FULL       = 3'd6;

  typedef struct packed {
    logic [3:0]               command;
    logic signed [WORD_W-1:0] push_value;
  } request_t;

  typedef struct packed {
    logic [1:0]               kind;
    logic signed [WORD_W-1:0] value;
    logic [2:0]               error_code;
    logic                     last;
  } result_t;

  typedef struct packed {
    logic              start;
    logic [WORD_W-1:0] dividend;
    logic [WORD_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic              done;
    logic [WORD_W-1:0] quotient;
    logic [WORD_W-1:0] remainder;
  } div_rsp_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DECODE,
    S_OPB,
    S_OPA,
    S_DIV,
    S_WALK,
    S_TOPV,
    S_CHARV,
    S_STR,
    S_RSCAN,
    S_RSTART,
    S_RWALK,
    S_LINE
  } state_t;

endpackage

/* sv/stack_machine_execute_unit.sv */
`timescale 1ns / 1ps

// Stack machine execute unit: a bounded stack of signed 32-bit words that runs
// one command per transfer. A command is taken when start is high and busy is
// low; busy then stays high until every result of that command has been put
// out. Results appear one per cycle on result, marked by result_valid for
// exactly one cycle, and the final one of a command carries last. The
// receiver cannot stall the unit, so it must take every result as it comes.
// The radix-2 divider works out the quotient bit by bit and then flags done.
// Print all streams the entries from the top down, as the stack RAM streams
// one word per cycle on its single read port. String and reversed string
// put out a run of text characters from the top, at most 32 of them; the
// reversed string scans the run once to find its end and then reads it back
// upward. The longest command is a reversed string over a full run.
// Errors leave the stack as it was and produce a single error result.
module stack_machine_execute_unit #(
  parameter int STACK_DEPTH = 32
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  smeu_pkg::request_t request,
  output logic               result_valid,
  output smeu_pkg::result_t  result
);

  localparam int AW = $clog2(STACK_DEPTH);       // RAM address width
  localparam int CW = $clog2(STACK_DEPTH + 1);   // entry count width
  localparam int W  = smeu_pkg::WORD_W;
  localparam int TW = smeu_pkg::TALLY_W;

  // control state
  smeu_pkg::state_t   state;
  smeu_pkg::state_t   state_next;
  logic [CW-1:0]      count;
  logic [CW-1:0]      count_next;

  // per-command registers
  smeu_pkg::request_t req_q;
  logic [W-1:0]       b_reg;
  logic [W-1:0]       b_reg_next;
  logic [AW-1:0]      ptr;
  logic [AW-1:0]      ptr_next;
  logic [TW-1:0]      tally;
  logic [TW-1:0]      tally_next;

  // result register
  smeu_pkg::result_t  res_next;
  logic               res_valid_next;

  // stack RAM ports
  logic               ram_we;
  logic [AW-1:0]      ram_waddr;
  logic [W-1:0]       ram_wdata;
  logic [AW-1:0]      ram_raddr;
  logic [W-1:0]       rd_data;

  // divider
  smeu_pkg::div_req_t div_req;
  smeu_pkg::div_rsp_t div_rsp;

  // shared ALU output
  logic [W-1:0]       alu_out;

  // decode helpers
  logic stack_full;
  logic stack_empty;
  logic too_few;
  logic is_divmod;
  logic rd_text;
  logic rd_char_ok;
  logic walk_end;
  logic text_end;
  logic rwalk_end;

  smeu_ram #(
    .WIDTH (W),
    .DEPTH (STACK_DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (rd_data)
  );

  smeu_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  assign busy = (state != smeu_pkg::S_IDLE);

  assign stack_full  = (count == CW'(STACK_DEPTH));
  assign stack_empty = (count == '0);
  assign too_few     = (count < CW'(2));
  assign is_divmod   = (req_q.command == smeu_pkg::CMD_DIV) ||
                       (req_q.command == smeu_pkg::CMD_MOD);
  // printable run: 1..127
  assign rd_text     = (rd_data[W-1:7] == '0) && (rd_data[6:0] != '0);
  assign rd_char_ok  = (rd_data[W-1:7] == '0);
  assign walk_end    = (ptr == '0) || (tally == TW'(smeu_pkg::MAX_RESULTS - 1));
  assign text_end    = (ptr == '0) || (tally == TW'(smeu_pkg::MAX_TEXT - 1));
  assign rwalk_end   = (ptr == AW'(count - CW'(1)));

  // wrapping add/sub/mul, second operand is the top
  always_comb begin
    case (req_q.command)
      smeu_pkg::CMD_ADD: alu_out = rd_data + b_reg;
      smeu_pkg::CMD_SUB: alu_out = rd_data - b_reg;
      default:           alu_out = rd_data * b_reg;
    endcase
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      smeu_pkg::S_IDLE: begin
        if (start) begin
          state_next = smeu_pkg::S_DECODE;
        end
      end
      smeu_pkg::S_DECODE: begin
        unique case (req_q.command) inside
          smeu_pkg::CMD_ADD, smeu_pkg::CMD_SUB, smeu_pkg::CMD_MUL,
          smeu_pkg::CMD_DIV, smeu_pkg::CMD_MOD: begin
            state_next = too_few ? smeu_pkg::S_IDLE : smeu_pkg::S_OPB;
          end
          smeu_pkg::CMD_PRINT: begin
            state_next = stack_empty ? smeu_pkg::S_IDLE : smeu_pkg::S_WALK;
          end
          smeu_pkg::CMD_TOP: begin
            state_next = stack_empty ? smeu_pkg::S_IDLE : smeu_pkg::S_TOPV;
          end
          smeu_pkg::CMD_CHAR: begin
            state_next = stack_empty ? smeu_pkg::S_IDLE : smeu_pkg::S_CHARV;
          end
          smeu_pkg::CMD_STRING: begin
            state_next = stack_empty ? smeu_pkg::S_LINE : smeu_pkg::S_STR;
          end
          smeu_pkg::CMD_RSTRING: begin
            state_next = stack_empty ? smeu_pkg::S_LINE : smeu_pkg::S_RSCAN;
          end
          default: begin
            // push and unknown codes finish here
            state_next = smeu_pkg::S_IDLE;
          end
        endcase
      end
      smeu_pkg::S_OPB: begin
        state_next = (is_divmod && rd_data == '0) ? smeu_pkg::S_IDLE : smeu_pkg::S_OPA;
      end
      smeu_pkg::S_OPA: begin
        state_next = is_divmod ? smeu_pkg::S_DIV : smeu_pkg::S_IDLE;
      end
      smeu_pkg::S_DIV: begin
        if (div_rsp.done) begin
          state_next = smeu_pkg::S_IDLE;
        end
      end
      smeu_pkg::S_WALK: begin
        if (walk_end) begin
          state_next = smeu_pkg::S_IDLE;
        end
      end
      smeu_pkg::S_TOPV: begin
        state_next = smeu_pkg::S_IDLE;
      end
      smeu_pkg::S_CHARV: begin
        state_next = rd_char_ok ? smeu_pkg::S_LINE : smeu_pkg::S_IDLE;
      end
      smeu_pkg::S_STR: begin
        if (!rd_text) begin
          state_next = smeu_pkg::S_IDLE;
        end else if (text_end) begin
          state_next = smeu_pkg::S_LINE;
        end
      end
      smeu_pkg::S_RSCAN: begin
        if (!rd_text) begin
          state_next = (tally == '0) ? smeu_pkg::S_IDLE : smeu_pkg::S_RSTART;
        end else if (text_end) begin
          state_next = smeu_pkg::S_RSTART;
        end
      end
      smeu_pkg::S_RSTART: begin
        state_next = smeu_pkg::S_RWALK;
      end
      smeu_pkg::S_RWALK: begin
        if (rwalk_end) begin
          state_next = smeu_pkg::S_LINE;
        end
      end
      smeu_pkg::S_LINE: begin
        state_next = smeu_pkg::S_IDLE;
      end
      default: begin
        state_next = smeu_pkg::S_IDLE;
      end
    endcase
  end

  // datapath and outputs
  always_comb begin
    count_next       = count;
    b_reg_next       = b_reg;
    ptr_next         = ptr;
    tally_next       = tally;
    res_valid_next   = 1'b0;
    res_next         = '0;
    ram_we           = 1'b0;
    ram_waddr        = AW'(count - CW'(2));
    ram_wdata        = alu_out;
    ram_raddr        = '0;
    div_req.start    = 1'b0;
    div_req.dividend = rd_data;
    div_req.divisor  = b_reg;

    unique case (state)
      smeu_pkg::S_IDLE: begin
      end
      smeu_pkg::S_DECODE: begin
        // read the top now; the walks start from it
        ram_raddr  = AW'(count - CW'(1));
        ptr_next   = AW'(count - CW'(1));
        tally_next = '0;
        unique case (req_q.command) inside
          smeu_pkg::CMD_PUSH: begin
            if (stack_full) begin
              res_valid_next      = 1'b1;
              res_next.kind       = smeu_pkg::KIND_ERROR;
              res_next.error_code = smeu_pkg::ERR_FULL;
              res_next.last       = 1'b1;
            end else begin
              ram_we     = 1'b1;
              ram_waddr  = AW'(count);
              ram_wdata  = req_q.push_value;
              count_next = count + CW'(1);
            end
          end
          smeu_pkg::CMD_ADD, smeu_pkg::CMD_SUB, smeu_pkg::CMD_MUL,
          smeu_pkg::CMD_DIV, smeu_pkg::CMD_MOD: begin
            if (too_few) begin
              res_valid_next      = 1'b1;
              res_next.kind       = smeu_pkg::KIND_ERROR;
              res_next.error_code = smeu_pkg::ERR_TOO_FEW;
              res_next.last       = 1'b1;
            end
          end
          smeu_pkg::CMD_TOP: begin
            if (stack_empty) begin
              res_valid_next      = 1'b1;
              res_next.kind       = smeu_pkg::KIND_ERROR;
              res_next.error_code = smeu_pkg::ERR_EMPTY_TOP;
              res_next.last       = 1'b1;
            end
          end
          smeu_pkg::CMD_CHAR: begin
            if (stack_empty) begin
              res_valid_next      = 1'b1;
              res_next.kind       = smeu_pkg::KIND_ERROR;
              res_next.error_code = smeu_pkg::ERR_EMPTY_CHAR;
              res_next.last       = 1'b1;
            end
          end
          default: begin
          end
        endcase
      end
      smeu_pkg::S_OPB: begin
        // top arrives; fetch the first operand below it
        b_reg_next = rd_data;
        ram_raddr  = AW'(count - CW'(2));
        if (is_divmod && rd_data == '0) begin
          res_valid_next      = 1'b1;
          res_next.kind       = smeu_pkg::KIND_ERROR;
          res_next.error_code = smeu_pkg::ERR_DIV_ZERO;
          res_next.last       = 1'b1;
        end
      end
      smeu_pkg::S_OPA: begin
        if (is_divmod) begin
          div_req.start = 1'b1;
        end else begin
          ram_we     = 1'b1;
          count_next = count - CW'(1);
        end
      end
      smeu_pkg::S_DIV: begin
        ram_wdata = (req_q.command == smeu_pkg::CMD_DIV) ? div_rsp.quotient
                                                          : div_rsp.remainder;
        if (div_rsp.done) begin
          ram_we     = 1'b1;
          count_next = count - CW'(1);
        end
      end
      smeu_pkg::S_WALK: begin
        // stream downward: data for ptr arrives while ptr-1 is read
        ram_raddr      = ptr - AW'(1);
        res_valid_next = 1'b1;
        res_next.kind  = smeu_pkg::KIND_NUMBER;
        res_next.value = rd_data;
        res_next.last  = walk_end;
        ptr_next       = ptr - AW'(1);
        tally_next     = tally + TW'(1);
      end
      smeu_pkg::S_TOPV: begin
        res_valid_next = 1'b1;
        res_next.kind  = smeu_pkg::KIND_NUMBER;
        res_next.value = rd_data;
        res_next.last  = 1'b1;
      end
      smeu_pkg::S_CHARV: begin
        res_valid_next = 1'b1;
        if (rd_char_ok) begin
          res_next.kind  = smeu_pkg::KIND_CHAR;
          res_next.value = rd_data;
        end else begin
          res_next.kind       = smeu_pkg::KIND_ERROR;
          res_next.error_code = smeu_pkg::ERR_CHAR_RANGE;
          res_next.last       = 1'b1;
        end
      end
      smeu_pkg::S_STR: begin
        ram_raddr      = ptr - AW'(1);
        res_valid_next = 1'b1;
        if (rd_text) begin
          res_next.kind  = smeu_pkg::KIND_CHAR;
          res_next.value = rd_data;
          ptr_next       = ptr - AW'(1);
          tally_next     = tally + TW'(1);
        end else begin
          // run ends at a non-text entry: line end closes the command
          res_next.kind  = smeu_pkg::KIND_LINE;
          res_next.value = smeu_pkg::LINE_FEED;
          res_next.last  = 1'b1;
        end
      end
      smeu_pkg::S_RSCAN: begin
        // measure the run only; it is printed bottom-up afterwards
        ram_raddr = ptr - AW'(1);
        if (rd_text) begin
          ptr_next   = ptr - AW'(1);
          tally_next = tally + TW'(1);
        end else if (tally == '0) begin
          res_valid_next = 1'b1;
          res_next.kind  = smeu_pkg::KIND_LINE;
          res_next.value = smeu_pkg::LINE_FEED;
          res_next.last  = 1'b1;
        end
      end
      smeu_pkg::S_RSTART: begin
        ram_raddr = AW'(count - CW'(tally));
        ptr_next  = AW'(count - CW'(tally));
      end
      smeu_pkg::S_RWALK: begin
        ram_raddr      = ptr + AW'(1);
        res_valid_next = 1'b1;
        res_next.kind  = smeu_pkg::KIND_CHAR;
        res_next.value = rd_data;
        ptr_next       = ptr + AW'(1);
      end
      smeu_pkg::S_LINE: begin
        res_valid_next = 1'b1;
        res_next.kind  = smeu_pkg::KIND_LINE;
        res_next.value = smeu_pkg::LINE_FEED;
        res_next.last  = 1'b1;
      end
      default: begin
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= smeu_pkg::S_IDLE;
      count        <= '0;
      result_valid <= 1'b0;
    end else begin
      state        <= state_next;
      count        <= count_next;
      result_valid <= res_valid_next;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (start && !busy) begin
      req_q <= request;
    end
    b_reg  <= b_reg_next;
    ptr    <= ptr_next;
    tally  <= tally_next;
    result <= res_next;
  end

endmodule

/* sv/smeu_ram.sv */
`timescale 1ns / 1ps

module smeu_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* sv/smeu_div.sv */
`timescale 1ns / 1ps

// Signed restoring divider, one quotient bit per cycle.
// Quotient truncates toward zero, remainder takes the dividend's sign.
module smeu_div (
  input  logic               clk,
  input  logic               rst,
  input  smeu_pkg::div_req_t req,
  output smeu_pkg::div_rsp_t rsp
);

  localparam int W  = smeu_pkg::WORD_W;
  localparam int CW = $clog2(W);

  logic [W-1:0]  quo;
  logic [W-1:0]  rem;
  logic [W-1:0]  dvs;
  logic          neg_q;
  logic          neg_r;
  logic [CW-1:0] step;
  logic          running;
  logic          done;

  logic [W:0]    shifted;
  logic [W:0]    diff;

  assign shifted = {rem, quo[W-1]};
  assign diff    = shifted - {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done    <= 1'b0;
      step    <= '0;
    end else begin
      done <= running && (step == CW'(W - 1));
      if (req.start) begin
        running <= 1'b1;
        step    <= '0;
      end else if (running) begin
        step <= step + CW'(1);
        if (step == CW'(W - 1)) begin
          running <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      quo   <= req.dividend[W-1] ? (~req.dividend + W'(1)) : req.dividend;
      dvs   <= req.divisor[W-1] ? (~req.divisor + W'(1)) : req.divisor;
      rem   <= '0;
      neg_q <= req.dividend[W-1] ^ req.divisor[W-1];
      neg_r <= req.dividend[W-1];
    end else if (running) begin
      if (!diff[W]) begin
        rem <= diff[W-1:0];
        quo <= {quo[W-2:0], 1'b1};
      end else begin
        rem <= shifted[W-1:0];
        quo <= {quo[W-2:0], 1'b0};
      end
    end
  end

  assign rsp.done      = done;
  assign rsp.quotient  = neg_q ? (~quo + W'(1)) : quo;
  assign rsp.remainder = neg_r ? (~rem + W'(1)) : rem;

endmodule

/* verif/stack_machine_checker.sv */
`timescale 1ns / 1ps

// Watches the command and result channels of the execute unit, keeps its own
// copy of the stack and queues the results each accepted command must give.
module stack_machine_checker #(
  parameter int STACK_DEPTH = 32
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic               busy,
  input  smeu_pkg::request_t request,
  input  logic               result_valid,
  input  smeu_pkg::result_t  result,
  output int                 mismatches,
  output int                 outstanding
);

  import smeu_pkg::*;

  logic [WORD_W-1:0] stack_words [STACK_DEPTH];
  int                stack_used = 0;
  int                error_count = 0;
  result_t           expected_results [$];

  initial begin
    mismatches  = 0;
    outstanding = 0;
  end

  function automatic result_t make_result(input logic [1:0] kind,
                                          input logic [WORD_W-1:0] value,
                                          input logic [2:0] code);
    result_t r;
    r.kind       = kind;
    r.value      = value;
    r.error_code = code;
    r.last       = 1'b0;
    return r;
  endfunction

  task automatic execute_command(input request_t rq);
    result_t           emitted [$];
    result_t           item;
    logic [WORD_W-1:0] a;
    logic [WORD_W-1:0] b;
    logic [WORD_W-1:0] r;
    int                cnt;
    int                run;
    int                i;
    cnt = stack_used;
    case (rq.command)
      CMD_PUSH: begin
        if (cnt >= STACK_DEPTH) begin
          emitted.push_back(make_result(KIND_ERROR, '0, ERR_FULL));
        end else begin
          stack_words[cnt] = rq.push_value;
          stack_used = cnt + 1;
        end
      end
      CMD_ADD, CMD_SUB, CMD_MUL, CMD_DIV, CMD_MOD: begin
        if (cnt < 2) begin
          emitted.push_back(make_result(KIND_ERROR, '0, ERR_TOO_FEW));
        end else begin
          a = stack_words[cnt-2];
          b = stack_words[cnt-1];
          if ((rq.command == CMD_DIV || rq.command == CMD_MOD) && b == '0) begin
            emitted.push_back(make_result(KIND_ERROR, '0, ERR_DIV_ZERO));
          end else begin
            case (rq.command)
              CMD_ADD: r = a + b;
              CMD_SUB: r = a - b;
              CMD_MUL: r = a * b;
              default: begin
                // divisor -1 handled apart: covers most-negative / -1 overflow
                if (b == '1)
                  r = (rq.command == CMD_DIV) ? (WORD_W'(0) - a) : '0;
                else if (rq.command == CMD_DIV)
                  r = $signed(a) / $signed(b);
                else
                  r = $signed(a) % $signed(b);
              end
            endcase
            stack_words[cnt-2] = r;
            stack_used = cnt - 1;
          end
        end
      end
      CMD_PRINT: begin
        for (i = cnt; i > 0 && emitted.size() < MAX_RESULTS; i--)
          emitted.push_back(make_result(KIND_NUMBER, stack_words[i-1], ERR_NONE));
      end
      CMD_TOP: begin
        if (cnt == 0)
          emitted.push_back(make_result(KIND_ERROR, '0, ERR_EMPTY_TOP));
        else
          emitted.push_back(make_result(KIND_NUMBER, stack_words[cnt-1], ERR_NONE));
      end
      CMD_CHAR: begin
        if (cnt == 0) begin
          emitted.push_back(make_result(KIND_ERROR, '0, ERR_EMPTY_CHAR));
        end else if (stack_words[cnt-1] > 127) begin
          emitted.push_back(make_result(KIND_ERROR, '0, ERR_CHAR_RANGE));
        end else begin
          emitted.push_back(make_result(KIND_CHAR, stack_words[cnt-1], ERR_NONE));
          emitted.push_back(make_result(KIND_LINE, LINE_FEED, ERR_NONE));
        end
      end
      CMD_STRING, CMD_RSTRING: begin
        run = 0;
        while (run < cnt && run < MAX_TEXT && stack_words[cnt-1-run] >= 1 &&
               stack_words[cnt-1-run] <= 127)
          run++;
        if (rq.command == CMD_STRING) begin
          for (i = 0; i < run; i++)
            emitted.push_back(make_result(KIND_CHAR, stack_words[cnt-1-i], ERR_NONE));
        end else begin
          for (i = run; i > 0; i--)
            emitted.push_back(make_result(KIND_CHAR, stack_words[cnt-i], ERR_NONE));
        end
        emitted.push_back(make_result(KIND_LINE, LINE_FEED, ERR_NONE));
      end
      default: ;
    endcase
    for (i = 0; i < emitted.size(); i++) begin
      item = emitted[i];
      item.last = (i == emitted.size() - 1);
      expected_results.push_back(item);
    end
  endtask

  always @(posedge clk) begin
    result_t want;
    if (rst) begin
      stack_used = 0;
      expected_results.delete();
    end else begin
      if (result_valid) begin
        if (expected_results.size() == 0) begin
          error_count++;
          if (error_count <= 10)
            $display("%0t: unexpected result kind %0d value %0d code %0d last %0b",
                     $time, result.kind, result.value, result.error_code, result.last);
        end else begin
          want = expected_results.pop_front();
          if (want.kind !== result.kind || want.value !== result.value ||
              want.error_code !== result.error_code || want.last !== result.last) begin
            error_count++;
            if (error_count <= 10)
              $display("%0t: result differs, want kind %0d value %0d code %0d last %0b, got kind %0d value %0d code %0d last %0b",
                       $time, want.kind, want.value, want.error_code, want.last,
                       result.kind, result.value, result.error_code, result.last);
          end
        end
      end
      if (start && !busy)
        execute_command(request);
    end
    mismatches  <= error_count;
    outstanding <= expected_results.size();
  end

endmodule

/* verif/testbench.sv */
`timescale 1ns / 1ps

// Top of the execute unit bench. Drives commands, leaves all prediction and
// comparison to the checker, and gives the verdict.
module testbench;

  import smeu_pkg::*;

  localparam int STACK_DEPTH  = 32;
  localparam int RANDOM_ITEMS = 500;
  // sized for the worst command (reversed string over a full run) plus
  // sender gaps at 67% idle, with a wide margin
  localparam int CYCLE_LIMIT  = 400000;
  localparam int SETTLE_CYCLES = 60;   // longer than a div/mod command

  localparam logic [3:0] ARITH_OPS [5] = '{CMD_ADD, CMD_SUB, CMD_MUL, CMD_DIV, CMD_MOD};
  localparam logic [3:0] PRINT_OPS [5] = '{CMD_PRINT, CMD_TOP, CMD_CHAR, CMD_STRING,
                                           CMD_RSTRING};

  logic     clk = 1'b0;
  logic     rst = 1'b1;
  logic     start = 1'b0;
  request_t request = '0;
  logic     busy;
  logic     result_valid;
  result_t  result;
  int       mismatches;
  int       outstanding;
  int       idle_pct = 0;
  int       cycle_count = 0;
  int       sent = 0;

  always #5 clk = ~clk;

  stack_machine_execute_unit #(.STACK_DEPTH(STACK_DEPTH)) dut (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .request      (request),
    .result_valid (result_valid),
    .result       (result)
  );

  stack_machine_checker #(.STACK_DEPTH(STACK_DEPTH)) result_check (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .request      (request),
    .result_valid (result_valid),
    .result       (result),
    .mismatches   (mismatches),
    .outstanding  (outstanding)
  );

  // watchdog: a hung handshake or a lost result ends the run here
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  // One command transfer. Called just after a falling edge. start is left
  // high on return so back-to-back commands never drop it between them; the
  // next call either keeps it up or lowers it once for a gap.
  task automatic issue(input logic [3:0] cmd, input logic [WORD_W-1:0] value);
    logic taken;
    while ($urandom_range(0, 99) < idle_pct) begin
      start <= 1'b0;
      @(negedge clk);
    end
    start   <= 1'b1;
    request <= '{command: cmd, push_value: value};
    // busy read right after the edge is its pre-edge value
    do begin
      @(posedge clk);
      taken = !busy;
    end while (!taken);
    sent++;
    @(negedge clk);
  endtask

  // sender holds off until every predicted result has come back
  task automatic wait_results_drained();
    start <= 1'b0;
    @(negedge clk);
    while (outstanding != 0)
      @(negedge clk);
  endtask

  // word mix weighted toward the corners: zero, both extremes, -1,
  // printable codes, just past the char range, small signed, and anything
  function automatic logic [WORD_W-1:0] pick_word();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return 32'h8000_0000;
      2:       return 32'h7fff_ffff;
      3:       return '1;
      4, 5:    return WORD_W'($urandom_range(1, 127));
      6:       return WORD_W'($urandom_range(0, 16)) - WORD_W'(8);
      7:       return WORD_W'($urandom_range(128, 300));
      default: return $urandom;
    endcase
  endfunction

  // One random burst. Bursts that grow the stack pop about as much back,
  // so the depth wanders instead of sticking at full.
  task automatic run_burst();
    int n;
    case ($urandom_range(0, 19))
      0, 1, 2, 3, 4, 5, 6: begin
        // operands then an operation
        n = $urandom_range(1, 3);
        repeat (n) issue(CMD_PUSH, pick_word());
        issue(ARITH_OPS[$urandom_range(0, 4)], pick_word());
      end
      7, 8, 9: begin
        // a word below the run, a text run, then one string command and a char on it
        n = ($urandom_range(0, 4) == 0) ? $urandom_range(9, 34) : $urandom_range(1, 8);
        issue(CMD_PUSH, pick_word());
        repeat (n) issue(CMD_PUSH, WORD_W'($urandom_range(1, 127)));
        issue($urandom_range(0, 1) ? CMD_STRING : CMD_RSTRING, $urandom);
        issue(CMD_CHAR, $urandom);
        repeat (n) issue(ARITH_OPS[$urandom_range(0, 2)], pick_word());
      end
      10, 11, 12: issue(PRINT_OPS[$urandom_range(0, 4)], $urandom);
      13, 14, 15: begin
        repeat ($urandom_range(2, 12)) issue(ARITH_OPS[$urandom_range(0, 4)], pick_word());
      end
      16, 17: issue(4'($urandom_range(0, 15)), $urandom);   // any code, unknown ones too
      default: begin
        // overfill, show everything, then fold most of it back
        repeat (STACK_DEPTH + 2)
          issue(CMD_PUSH, $urandom_range(0, 1) ? WORD_W'($urandom_range(1, 127)) : pick_word());
        issue(CMD_PRINT, $urandom);
        issue(CMD_STRING, $urandom);
        issue(CMD_RSTRING, $urandom);
        repeat (STACK_DEPTH - 2) issue(ARITH_OPS[$urandom_range(0, 4)], pick_word());
      end
    endcase
  endtask

  initial begin
    int goal;
    int phase;
    repeat (6) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // directed: empty-stack errors, extremes, overflowing division,
    // divide by zero, text runs, char range, unknown codes
    issue(CMD_ADD, '0);                 // too few
    issue(CMD_TOP, '0);                 // empty top
    issue(CMD_CHAR, '0);                // empty char
    issue(CMD_STRING, '0);              // line end only
    issue(CMD_PRINT, '0);               // nothing at all
    issue(CMD_PUSH, 32'h8000_0000);
    issue(CMD_DIV, '1);                 // one entry, too few
    issue(CMD_PUSH, '1);
    issue(CMD_DIV, '0);                 // most negative / -1 wraps
    issue(CMD_PUSH, '1);
    issue(CMD_MOD, '0);                 // remainder of that is zero
    issue(CMD_PUSH, '0);
    issue(CMD_DIV, '0);                 // divide by zero
    issue(CMD_MUL, '0);
    issue(CMD_PUSH, WORD_W'(72));
    issue(CMD_PUSH, WORD_W'(105));
    issue(CMD_PUSH, WORD_W'(33));
    issue(CMD_STRING, '0);              // run stops at the zero below
    issue(CMD_RSTRING, '0);
    issue(CMD_CHAR, '0);
    issue(CMD_TOP, '0);
    issue(CMD_ADD, '0);
    issue(CMD_CHAR, '0);                // 138: out of char range
    issue(CMD_SUB, '0);
    issue(CMD_PRINT, '0);
    issue(4'd11, '1);
    issue(4'd15, '1);
    wait_results_drained();

    // random, three gap regimes, each closed by a full drain
    goal = sent;
    for (phase = 0; phase < 3; phase++) begin
      idle_pct = (phase == 0) ? 19 : (phase == 1) ? 67 : 0;
      goal += RANDOM_ITEMS / 3;
      while (sent < goal)
        run_burst();
      wait_results_drained();
    end

    // let any late stray result show up before judging
    repeat (SETTLE_CYCLES) @(negedge clk);
    if (mismatches == 0 && outstanding == 0)
      $display("end of test: clean");
    else
      $display("end of test: mismatches");
    $finish;
  end

endmodule
